// ----- rtl/core/hcm_pkg.sv -----
// Shared types, constants and helpers for the hotkey chord matcher.
package hcm_pkg;

   localparam int NUM_WORDS       = 4;
   localparam int WORD_W          = 24;
   localparam int CSR_IDX_W       = 2;
   localparam int DEF_NUM_BINDINGS = 4;
   localparam int DEF_HELD_DEPTH  = 8;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] SC_CTRL   = 8'h1D;
   localparam logic [7:0] SC_ALT    = 8'h38;
   localparam logic [7:0] SC_LSHIFT = 8'h2A;
   localparam logic [7:0] SC_RSHIFT = 8'h36;
   localparam logic [7:0] SC_LMETA  = 8'h5B;
   localparam logic [7:0] SC_RMETA  = 8'h5C;

   localparam logic [1:0] ACT_UNSUPPORTED = 2'd3;

   typedef struct packed {
      logic [7:0] scan_code;
      logic       extended;
      logic [7:0] virtual_key;
      logic       is_down;
   } hcm_req_type;

   typedef struct packed {
      logic [1:0] binding_slot;
      logic [1:0] action_code;
      logic       pressed;
      logic       last;
   } hcm_rsp_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] action;
      logic [3:0] mods;
      logic [7:0] vkey;
      logic       extended;
      logic [7:0] scan;
   } hcm_word_type;

   typedef struct packed {
      logic       valid;
      logic       extended;
      logic [7:0] scan;
   } hcm_key_type;

   typedef struct packed {
      logic [NUM_WORDS-1:0]      slot_mask;
      logic [NUM_WORDS-1:0][1:0] actions;
      logic                      pressed;
   } hcm_job_type;

   function automatic logic shared_scan(input logic [7:0] s);
      return s == 8'h1C || s == 8'h47 || s == 8'h48 || s == 8'h49 ||
             s == 8'h4B || s == 8'h4D || s == 8'h4F || s == 8'h50 ||
             s == 8'h51 || s == 8'h52 || s == 8'h53;
   endfunction

endpackage

// ----- rtl/core/hcm_front.sv -----
// Front end: accepts key events, tracks modifiers, held keys and active bindings, emits jobs.
module hcm_front import hcm_pkg::*; #(
   parameter int NUM_BINDINGS = DEF_NUM_BINDINGS,
   parameter int HELD_DEPTH   = DEF_HELD_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hcm_req_type          req_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata,
   input  logic                 job_ready,
   output logic                 job_valid,
   output hcm_job_type          job_data
);

   localparam int SLOTS  = (NUM_BINDINGS < NUM_WORDS) ? NUM_BINDINGS : NUM_WORDS;
   localparam int HIDX_W = $clog2(HELD_DEPTH);

   hcm_word_type            words_ff  [SLOTS];
   hcm_word_type            words_in  [SLOTS];
   hcm_key_type             held_ff   [HELD_DEPTH];
   hcm_key_type             held_in   [HELD_DEPTH];
   logic [7:0]              flags_ff, flags_in;
   logic [SLOTS-1:0]        active_ff, active_in;

   logic                    accept;
   logic                    is_mod;
   logic [2:0]              mod_bit;
   logic [3:0]              mods;
   logic [SLOTS-1:0]        match;
   logic [SLOTS-1:0]        cand;
   logic [SLOTS-1:0]        sel_oh;
   logic [SLOTS-1:0]        rel;
   logic                    any;
   logic                    held_hit;
   logic                    free_found;
   logic [HIDX_W-1:0]       free_idx;
   logic                    both;
   hcm_key_type             key_a, key_b;

   assign req_ready = job_ready;
   assign accept    = req_valid && req_ready;
   assign mods      = {|flags_ff[7:6], |flags_ff[5:4], |flags_ff[3:2], |flags_ff[1:0]};
   assign key_a     = '{valid: 1'b1, extended: req_data.extended, scan: req_data.scan_code};
   assign key_b     = '{valid: 1'b1, extended: ~req_data.extended, scan: req_data.scan_code};
   assign both      = shared_scan(req_data.scan_code);

   always_comb begin
      is_mod  = 1'b1;
      mod_bit = 3'd0;
      if (req_data.scan_code == SC_CTRL) begin
         mod_bit = req_data.extended ? 3'd1 : 3'd0;
      end else if (req_data.scan_code == SC_ALT) begin
         mod_bit = req_data.extended ? 3'd3 : 3'd2;
      end else if (!req_data.extended && req_data.scan_code == SC_LSHIFT) begin
         mod_bit = 3'd4;
      end else if (!req_data.extended && req_data.scan_code == SC_RSHIFT) begin
         mod_bit = 3'd5;
      end else if (req_data.extended && req_data.scan_code == SC_LMETA) begin
         mod_bit = 3'd6;
      end else if (req_data.extended && req_data.scan_code == SC_RMETA) begin
         mod_bit = 3'd7;
      end else begin
         is_mod = 1'b0;
      end
   end

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match[i] = words_ff[i].valid && words_ff[i].action != ACT_UNSUPPORTED &&
                    words_ff[i].scan == req_data.scan_code &&
                    words_ff[i].extended == req_data.extended &&
                    (words_ff[i].vkey == 8'd0 || words_ff[i].vkey == req_data.virtual_key);
         cand[i]  = match[i] && words_ff[i].mods == mods;
      end
      any    = |match;
      sel_oh = cand & (~cand + SLOTS'(1));
      rel    = active_ff & match;
   end

   always_comb begin
      held_hit   = 1'b0;
      free_found = 1'b0;
      free_idx   = '0;
      for (int j = 0; j < HELD_DEPTH; j++) begin
         if (held_ff[j] == key_a) held_hit = 1'b1;
         if (!free_found && !held_ff[j].valid) begin
            free_found = 1'b1;
            free_idx   = HIDX_W'(j);
         end
      end
   end

   always_comb begin
      flags_in  = flags_ff;
      held_in   = held_ff;
      active_in = active_ff;
      words_in  = words_ff;
      job_valid = 1'b0;
      job_data  = '0;
      for (int i = 0; i < SLOTS; i++) begin
         job_data.actions[i] = words_ff[i].action;
      end
      if (accept) begin
         if (is_mod) begin
            flags_in[mod_bit] = req_data.is_down;
         end else if (!req_data.is_down) begin
            for (int j = 0; j < HELD_DEPTH; j++) begin
               if (held_ff[j] == key_a || (both && held_ff[j] == key_b)) held_in[j] = '0;
            end
            if (any && rel != '0) begin
               active_in          = active_ff & ~rel;
               job_valid          = 1'b1;
               job_data.slot_mask = NUM_WORDS'(rel);
               job_data.pressed   = 1'b0;
            end
         end else if (any && !held_hit) begin
            if (free_found) held_in[free_idx] = key_a;
            if (sel_oh != '0 && (sel_oh & active_ff) == '0) begin
               active_in          = active_ff | sel_oh;
               job_valid          = 1'b1;
               job_data.slot_mask = NUM_WORDS'(sel_oh);
               job_data.pressed   = 1'b1;
            end
         end
      end
      if (csr_wr_en) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (csr_index == CSR_IDX_W'(i)) begin
               words_in[i]  = hcm_word_type'(csr_wdata);
               active_in[i] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff  <= '0;
         active_ff <= '0;
         for (int j = 0; j < HELD_DEPTH; j++) held_ff[j] <= '0;
         for (int i = 0; i < SLOTS; i++) words_ff[i] <= '0;
      end else begin
         flags_ff  <= flags_in;
         active_ff <= active_in;
         held_ff   <= held_in;
         words_ff  <= words_in;
      end
   end

endmodule

// ----- rtl/core/hcm_queue.sv -----
// Short job queue between the front end and the result sequencer.
module hcm_queue import hcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  hcm_job_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output hcm_job_type out_data
);

   hcm_job_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   assign in_ready  = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) count_in = count_ff + QCNT_W'(1);
      else if (pop && !push) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/core/hcm_back.sv -----
// Result sequencer: walks a job's slot mask in slot order, one result beat per cycle unless rsp_ready holds the output.
module hcm_back import hcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   output logic        job_ready,
   input  hcm_job_type job_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output hcm_rsp_type rsp_data
);

   logic                 busy_ff, busy_in;
   hcm_job_type          cur_ff, cur_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   hcm_rsp_type          rsp_ff, rsp_in;
   logic [NUM_WORDS-1:0] low_oh;
   logic [NUM_WORDS-1:0] rest;
   logic [1:0]           slot;
   logic [1:0]           act;
   logic                 emit, finish;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      low_oh = cur_ff.slot_mask & (~cur_ff.slot_mask + NUM_WORDS'(1));
      rest   = cur_ff.slot_mask & ~low_oh;
      slot   = '0;
      act    = '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
         if (low_oh[i]) begin
            slot = 2'(i);
            act  = cur_ff.actions[i];
         end
      end
      emit      = busy_ff && (!rsp_valid_ff || rsp_ready);
      finish    = emit && rest == '0;
      job_ready = !busy_ff || finish;

      busy_in      = busy_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{binding_slot: slot, action_code: act,
                          pressed: cur_ff.pressed, last: rest == '0};
         cur_in.slot_mask = rest;
      end
      if (job_valid && job_ready) begin
         busy_in = 1'b1;
         cur_in  = job_data;
      end else if (finish) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/hotkey_chord_matcher_top.sv -----
// Top level of the hotkey chord matcher.
//
// req_* takes one key event per beat (scan code, extended flag, virtual key,
// down/up). rsp_* gives the resulting chord changes, one binding per beat,
// in slot order, with last set on the final beat of an event. Modifier keys,
// repeats of held keys and unbound keys give no beat at all.
// csr_* writes binding words (index 0..3); writing one clears its active bit.
// An event's results pass through the job queue, the sequencer's job register and its output register.
// Throughput: one event per cycle into the front end while req_ready is high;
// the sequencer emits one result beat per cycle unless rsp_ready holds it.
// A two-entry job queue sits between front end and sequencer; when rsp_ready
// is low the output register holds, the queue fills and req_ready drops.
// Reset clears modifier flags, held keys, active bits, binding words and
// all queued work; req_ready is high as soon as reset is released.
module hotkey_chord_matcher_top import hcm_pkg::*; #(
   parameter int NUM_BINDINGS = DEF_NUM_BINDINGS,
   parameter int HELD_DEPTH   = DEF_HELD_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hcm_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hcm_rsp_type          rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   logic        fq_valid, fq_ready;
   hcm_job_type fq_data;
   logic        qb_valid, qb_ready;
   hcm_job_type qb_data;

   hcm_front #(
      .NUM_BINDINGS (NUM_BINDINGS),
      .HELD_DEPTH   (HELD_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .job_ready (fq_ready),
      .job_valid (fq_valid),
      .job_data  (fq_data)
   );

   hcm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   hcm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qb_valid),
      .job_ready (qb_ready),
      .job_data  (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
